### hdl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Request codes, register indexes, field widths and the stage tag struct.
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int VAL_W    = 16;   // signed Q8.8 element
	localparam int PROD_W   = 32;   // signed Q16.16 product
	localparam int ACC_W    = 48;   // wrapping accumulator
	localparam int SUM_W    = 32;   // saturated Q16.16 row sum
	localparam int ROWIX_W  = 12;   // row_index port width
	localparam int VIDX_W   = 10;   // vec_index port width
	localparam int RCNT_W   = 13;   // row_count register width
	localparam int CCNT_W   = 11;   // col_count register width
	localparam int CFG_W    = 13;   // widest register
	localparam int CNT_W    = 17;   // holds any count up to 65536

	typedef enum logic {
		REQ_VECTOR = 1'b0,
		REQ_WEIGHT = 1'b1
	} req_t;

	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_idx_t;

	// what travels alongside a weight through the pipeline
	typedef struct packed {
		logic               end_row;
		logic               last_row;
		logic [ROWIX_W-1:0] row_idx;
	} tag_t;

endpackage

### hdl/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply: fixed-point y = W * x
// Vector elements are written into a store; weights stream row-major, each
// is multiplied by the stored element of its column and summed per row.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  req_type, vec_index, value
//   out      source     out_valid/out_stall row_index, row_sum, last_row
//   cfg      sink       cfg_write          cfg_index, cfg_data
//
// One transaction per cycle on the input, loads and weights alike, while in_stall is low.
// A weight reads the vector store at its accept edge (s1), is multiplied
// in s2 and summed into the accumulator on the way to the output register,
// where the row result is registered after the row's last weight leaves s2.
// Reset clears positions and accumulator and sets both counts to one; the store is not cleared.
// Loads are never stalled; a weight stalls only while the pipeline is full
// behind a row result that the output cannot hand off.
// ----------------------------------------------------------------------------
module matrix_vector_multiply
	import mvm_pkg::*;
#(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [VIDX_W-1:0]   vec_index,
	input  logic signed [VAL_W-1:0] value,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ROWIX_W-1:0]  row_index,
	output logic signed [SUM_W-1:0] row_sum,
	output logic                last_row,
	// configuration
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// effective counts, clamped at write time
	logic [CNT_W-1:0] eff_rows_q, eff_cols_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;

	logic             s1_valid_q;
	tag_t             s1_tag_s1;
	logic [VAL_W-1:0] weight_s1;

	logic             s2_valid_q;
	tag_t             s2_tag_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic [ACC_W-1:0] acc_q;
	logic             out_valid_q;
	logic [ROWIX_W-1:0] row_index_q;
	logic [SUM_W-1:0] row_sum_q;
	logic             last_row_q;

	logic             out_busy, s2_go, s1_go;
	logic             in_acc, wt_acc, ld_acc;
	logic             end_row, fin_row;
	logic [CNT_W-1:0] col_next, row_next;
	logic [RW+ROWIX_W-1:0] row_ext;
	logic [CW+VIDX_W-1:0]  vidx_ext;
	logic             ld_in_range;
	logic [VAL_W-1:0] x_rd;
	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0] sum;
	logic [SUM_W-1:0] sat;
	logic [RCNT_W-1:0] rc_w;
	logic [CCNT_W-1:0] cc_w;
	logic [CNT_W-1:0] rows_clamp, cols_clamp;

	// ---------------- flow control ----------------
	assign out_busy = out_valid_q && out_stall;
	assign s2_go    = !s2_valid_q || !(s2_tag_s2.end_row && out_busy);
	assign s1_go    = !s1_valid_q || s2_go;

	assign in_stall = (req_t'(req_type) == REQ_WEIGHT) && !s1_go;
	assign in_acc   = in_valid && !in_stall;
	assign wt_acc   = in_acc && (req_t'(req_type) == REQ_WEIGHT);
	assign ld_acc   = in_acc && (req_t'(req_type) == REQ_VECTOR);

	// ---------------- configuration ----------------
	assign rc_w = cfg_data[RCNT_W-1:0];
	assign cc_w = cfg_data[CCNT_W-1:0];

	always_comb begin
		if (rc_w == '0)
			rows_clamp = CNT_W'(1);
		else if (CNT_W'(rc_w) > CNT_W'(MAX_ROWS))
			rows_clamp = CNT_W'(MAX_ROWS);
		else
			rows_clamp = CNT_W'(rc_w);
		if (cc_w == '0)
			cols_clamp = CNT_W'(1);
		else if (CNT_W'(cc_w) > CNT_W'(MAX_COLS))
			cols_clamp = CNT_W'(MAX_COLS);
		else
			cols_clamp = CNT_W'(cc_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_rows_q <= CNT_W'(1);
			eff_cols_q <= CNT_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW_COUNT: eff_rows_q <= rows_clamp;
				REG_COL_COUNT: eff_cols_q <= cols_clamp;
				default: ;
			endcase
		end
	end

	// ---------------- positions ----------------
	assign col_next = CNT_W'(col_q) + CNT_W'(1);
	assign row_next = CNT_W'(row_q) + CNT_W'(1);
	assign end_row  = col_next >= eff_cols_q;
	assign fin_row  = row_next >= eff_rows_q;
	assign row_ext  = {{ROWIX_W{1'b0}}, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (wt_acc) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= fin_row ? '0 : row_next[RW-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	// ---------------- vector store ----------------
	assign vidx_ext    = {{CW{1'b0}}, vec_index};
	assign ld_in_range = CNT_W'(vec_index) < CNT_W'(MAX_COLS);

	mvm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_COLS)
	) u_store (
		.clk    (clk),
		.wr_en  (ld_acc && ld_in_range),
		.wr_addr(vidx_ext[CW-1:0]),
		.wr_data(value),
		.rd_en  (s1_go),
		.rd_addr(col_q),
		.rd_data(x_rd)
	);

	// ---------------- s1: store read in flight ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_go) begin
			s1_valid_q <= wt_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			weight_s1         <= value;
			s1_tag_s1.end_row  <= end_row;
			s1_tag_s1.last_row <= fin_row;
			s1_tag_s1.row_idx  <= row_ext[ROWIX_W-1:0];
		end
	end

	// ---------------- s2: product ----------------
	assign prod = $signed(weight_s1) * $signed(x_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_go) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			prod_s2   <= prod;
			s2_tag_s2 <= s1_tag_s1;
		end
	end

	// ---------------- accumulate, saturate, output ----------------
	assign sum = acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_comb begin
		if ((&sum[ACC_W-1:SUM_W-1]) || !(|sum[ACC_W-1:SUM_W-1]))
			sat = sum[SUM_W-1:0];
		else if (sum[ACC_W-1])
			sat = {1'b1, {(SUM_W-1){1'b0}}};
		else
			sat = {1'b0, {(SUM_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_go && s2_valid_q) begin
				acc_q <= s2_tag_s2.end_row ? '0 : sum;
			end
			if (s2_go && s2_valid_q && s2_tag_s2.end_row) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2_valid_q && s2_tag_s2.end_row) begin
			row_index_q <= s2_tag_s2.row_idx;
			row_sum_q   <= sat;
			last_row_q  <= s2_tag_s2.last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_sum   = row_sum_q;
	assign last_row  = last_row_q;

	// ---------------- assertions ----------------
	// a row end held back by the output keeps its product
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && s2_tag_s2.end_row && out_busy) |=>
		(s2_valid_q && $stable(prod_s2)))
		else $error("s2 row end lost while output stalled");

	// the final weight of the matrix rewinds both positions
	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(wt_acc && end_row && fin_row) |=> (col_q == '0 && row_q == '0))
		else $error("positions not rewound after final row");

	// emitting a row clears the accumulator
	a_acc_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && s2_valid_q && s2_tag_s2.end_row) |=> (acc_q == '0 && out_valid_q))
		else $error("accumulator not cleared at row end");

	// a weight is refused only while s1 and s2 are occupied and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && s2_valid_q && out_busy))
		else $error("weight refused with room in the pipeline");

endmodule
